FILE: hw/rtl/fpw_pkg.sv
package fpw_pkg;

    localparam int PA_BITS    = 52;
    localparam int VA_BITS    = 48;
    localparam int ENTRY_BITS = 64;
    localparam int IDX_BITS   = 9;

    localparam logic [PA_BITS-1:0] FRAME_4K  = PA_BITS'(52'hFFFFFFFFFF000);
    localparam logic [PA_BITS-1:0] FRAME_1G  = PA_BITS'(52'hFFFFFC0000000);
    localparam logic [PA_BITS-1:0] FRAME_2M  = PA_BITS'(52'hFFFFFFFE00000);
    localparam logic [29:0]        OFFS_1G   = 30'h3FFFFFFF;
    localparam logic [20:0]        OFFS_2M   = 21'h1FFFFF;
    localparam logic [11:0]        OFFS_4K   = 12'hFFF;
    localparam int                 LARGE_BIT = 7;

    localparam logic OP_REQUEST  = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_READ_FAIL   = 2'd1;
    localparam logic [1:0] ST_EMPTY       = 2'd2;
    localparam logic [1:0] ST_IDLE_RESP   = 2'd3;

    typedef enum logic [2:0] {
        WALK_IDLE = 3'd0,
        WALK_L0   = 3'd1,
        WALK_L1   = 3'd2,
        WALK_L2   = 3'd3,
        WALK_L3   = 3'd4
    } walk_step_t;

    typedef struct packed {
        logic                  operation;
        logic [VA_BITS-1:0]    virtual_address;
        logic [ENTRY_BITS-1:0] entry_data;
        logic                  read_ok;
    } fpw_in_t;

    typedef struct packed {
        logic               result_kind;
        logic [PA_BITS-1:0] entry_address;
        logic [PA_BITS-1:0] phys_addr;
        logic [1:0]         status;
        logic [1:0]         fault_level;
    } fpw_out_t;

endpackage

FILE: hw/rtl/four_level_page_walker_core.sv
// Four-level page walker. A request beat (tuser = 0) latches the virtual address and returns
// an entry read beat carrying the top-level entry address; each response beat (tuser = 1)
// returns either the next entry address or a finished beat with the physical address, or
// zero with a status and fault level on failure. One beat is taken every clock: a beat
// passes an input register, the walk logic and a result register, and the walk state is
// updated as the beat leaves the input register, which lets the next beat follow straight
// behind. Throughput drops only while the result register is held by m_tready low.
// root_table_base is written over cfg_*; the user must write it only while no beat is in
// flight, as the block itself does not enforce this.
module four_level_page_walker_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [47:0] virtual_address, [111:48] entry_data, [112] read_ok, [119:113] zero
    input  logic [119:0]               s_tdata,
    // [0] operation
    input  logic [0:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [51:0] entry_address, [103:52] phys_addr, [105:104] status,
    // [107:106] fault_level
    output logic [111:0]               m_tdata,
    // [0] result_kind
    output logic [0:0]                 m_tuser,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fpw_pkg::PA_BITS-1:0] cfg_data
);
    import fpw_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    fpw_in_t            in_item_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    fpw_out_t           out_item_reg;
    fpw_out_t           res;
    logic [PA_BITS-1:0] root_reg;
    logic               advance;
    logic               item_fire;
    logic               s_fire;

    assign advance   = !out_valid_reg || m_tready;
    assign item_fire = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (item_fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    fpw_walk u_walk (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_fire       (item_fire),
        .item            (in_item_reg),
        .root_table_base (root_reg),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            root_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                root_reg <= cfg_data;
        end
    end

    // payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.operation       <= s_tuser[0];
            in_item_reg.virtual_address <= s_tdata[47:0];
            in_item_reg.entry_data      <= s_tdata[111:48];
            in_item_reg.read_ok         <= s_tdata[112];
        end
        if (item_fire)
            out_item_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_item_reg.result_kind;
    assign m_tdata  = {4'b0000, out_item_reg.fault_level, out_item_reg.status,
                       out_item_reg.phys_addr, out_item_reg.entry_address};

endmodule

FILE: hw/rtl/fpw_walk.sv
module fpw_walk (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_fire,
    input  fpw_pkg::fpw_in_t           item,
    input  logic [fpw_pkg::PA_BITS-1:0] root_table_base,
    output fpw_pkg::fpw_out_t          res
);
    import fpw_pkg::*;

    walk_step_t          step_reg;
    walk_step_t          step_next;
    logic [VA_BITS-1:0]  hva_reg;
    logic [VA_BITS-1:0]  hva_next;

    logic [1:0]          level;
    logic [1:0]          next_level;
    logic                walking;
    logic                big_page;
    logic [PA_BITS-1:0]  entry_pa;
    logic [IDX_BITS-1:0] req_idx;
    logic [IDX_BITS-1:0] next_idx;

    function automatic logic [IDX_BITS-1:0] level_index(input logic [VA_BITS-1:0] va,
                                                         input logic [1:0] lvl);
        logic [IDX_BITS-1:0] idx;
        case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            2'd3:    idx = va[20:12];
            default: idx = va[47:39];
        endcase
        return idx;
    endfunction

    function automatic logic [PA_BITS-1:0] idx_offset(input logic [IDX_BITS-1:0] idx);
        return {{(PA_BITS-IDX_BITS-3){1'b0}}, idx, 3'b000};
    endfunction

    always_comb
    begin
        case (step_reg)
            WALK_L0: begin walking = 1'b1; level = 2'd0; end
            WALK_L1: begin walking = 1'b1; level = 2'd1; end
            WALK_L2: begin walking = 1'b1; level = 2'd2; end
            WALK_L3: begin walking = 1'b1; level = 2'd3; end
            default: begin walking = 1'b0; level = 2'd0; end
        endcase
    end

    assign next_level = level + 2'd1;
    assign big_page   = item.entry_data[LARGE_BIT];
    assign entry_pa   = item.entry_data[PA_BITS-1:0];
    assign req_idx    = level_index(item.virtual_address, 2'd0);
    assign next_idx   = level_index(hva_reg, next_level);

    // next state
    always_comb
    begin
        step_next = step_reg;
        hva_next  = hva_reg;
        if (item_fire)
        begin
            if (item.operation == OP_REQUEST)
            begin
                step_next = WALK_L0;
                hva_next  = item.virtual_address;
            end
            else if (!walking || !item.read_ok || item.entry_data == '0)
            begin
                step_next = WALK_IDLE;
            end
            else
            begin
                case (step_reg)
                    WALK_L0: step_next = WALK_L1;
                    WALK_L1: step_next = big_page ? WALK_IDLE : WALK_L2;
                    WALK_L2: step_next = big_page ? WALK_IDLE : WALK_L3;
                    default: step_next = WALK_IDLE;
                endcase
            end
        end
    end

    // result
    always_comb
    begin
        res = '0;
        if (item.operation == OP_REQUEST)
        begin
            res.result_kind   = KIND_READ;
            res.entry_address = root_table_base + idx_offset(req_idx);
        end
        else if (!walking)
        begin
            res.result_kind = KIND_DONE;
            res.status      = ST_IDLE_RESP;
        end
        else if (!item.read_ok)
        begin
            res.result_kind = KIND_DONE;
            res.status      = ST_READ_FAIL;
            res.fault_level = level;
        end
        else if (item.entry_data == '0)
        begin
            res.result_kind = KIND_DONE;
            res.status      = ST_EMPTY;
            res.fault_level = level;
        end
        else if (level == 2'd1 && big_page)
        begin
            res.result_kind = KIND_DONE;
            res.phys_addr   = (entry_pa & FRAME_1G)
                            + {{(PA_BITS-30){1'b0}}, hva_reg[29:0] & OFFS_1G};
        end
        else if (level == 2'd2 && big_page)
        begin
            res.result_kind = KIND_DONE;
            res.phys_addr   = (entry_pa & FRAME_2M)
                            + {{(PA_BITS-21){1'b0}}, hva_reg[20:0] & OFFS_2M};
        end
        else if (level == 2'd3)
        begin
            res.result_kind = KIND_DONE;
            res.phys_addr   = (entry_pa & FRAME_4K)
                            + {{(PA_BITS-12){1'b0}}, hva_reg[11:0] & OFFS_4K};
        end
        else
        begin
            res.result_kind   = KIND_READ;
            res.entry_address = (entry_pa & FRAME_4K) + idx_offset(next_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= WALK_IDLE;
            hva_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            hva_reg  <= hva_next;
        end
    end

    a_req_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.operation == OP_REQUEST |=> step_reg == WALK_L0)
        else $error("request did not start a walk at the top level");

    a_read_keeps_walking: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && res.result_kind == KIND_READ |=> step_reg != WALK_IDLE)
        else $error("entry read issued but walk went idle");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && res.result_kind == KIND_DONE |=> step_reg == WALK_IDLE)
        else $error("walk finished but state not idle");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !item_fire |=> $stable(step_reg) && $stable(hva_reg))
        else $error("walk state moved without an item");

endmodule

FILE: bench/four_level_page_walker_core_tb.sv
`timescale 1ns / 1ps

module four_level_page_walker_core_tb;
    import fpw_pkg::*;

    localparam int RUN_ITEMS      = 1780;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int LARGE_PAGE_BIT = 7;

    class translation_tracker;
        logic [PA_BITS-1:0] root_base;
        walk_step_t         step;
        logic [VA_BITS-1:0] held_va;
        fpw_out_t           pending_results[$];
        int                 mismatches;
        int                 beats_in;
        int                 beats_out;
        int                 pages_4k;
        int                 pages_2m;
        int                 pages_1g;
        int                 faults;
        int                 idle_responses;

        function new();
            root_base      = '0;
            step           = WALK_IDLE;
            held_va        = '0;
            mismatches     = 0;
            beats_in       = 0;
            beats_out      = 0;
            pages_4k       = 0;
            pages_2m       = 0;
            pages_1g       = 0;
            faults         = 0;
            idle_responses = 0;
        endfunction

        function logic [8:0] table_index(logic [VA_BITS-1:0] va, int level);
            return va[39 - 9 * level +: 9];
        endfunction

        // Advance the walk by one accepted beat and queue the result it must produce.
        function void take_beat(logic op, logic [VA_BITS-1:0] va,
                                logic [ENTRY_BITS-1:0] entry, logic ok);
            fpw_out_t r;
            int       lvl;
            r = '0;
            beats_in++;
            if (op == OP_REQUEST) begin
                held_va         = va;
                step            = WALK_L0;
                r.result_kind   = KIND_READ;
                r.entry_address = root_base + {table_index(va, 0), 3'b000};
            end else if (step < WALK_L0 || step > WALK_L3) begin
                step          = WALK_IDLE;
                r.result_kind = KIND_DONE;
                r.status      = ST_IDLE_RESP;
                idle_responses++;
            end else begin
                lvl           = int'(step) - 1;
                step          = WALK_IDLE;
                r.result_kind = KIND_DONE;
                if (!ok) begin
                    r.status      = ST_READ_FAIL;
                    r.fault_level = 2'(lvl);
                    faults++;
                end else if (entry == '0) begin
                    r.status      = ST_EMPTY;
                    r.fault_level = 2'(lvl);
                    faults++;
                end else if (lvl == 1 && entry[LARGE_PAGE_BIT]) begin
                    r.phys_addr = {entry[51:30], held_va[29:0]};
                    pages_1g++;
                end else if (lvl == 2 && entry[LARGE_PAGE_BIT]) begin
                    r.phys_addr = {entry[51:21], held_va[20:0]};
                    pages_2m++;
                end else if (lvl == 3) begin
                    r.phys_addr = {entry[51:12], held_va[11:0]};
                    pages_4k++;
                end else begin
                    r.result_kind   = KIND_READ;
                    r.entry_address = {entry[51:12], 12'h000}
                                      + {table_index(held_va, lvl + 1), 3'b000};
                    step            = walk_step_t'(lvl + 2);
                end
            end
            pending_results = {pending_results, r};
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(fpw_out_t got);
            fpw_out_t want;
            beats_out++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", 64'(got.entry_address), '0);
                return;
            end
            want = pending_results.pop_front();
            if (got.result_kind != want.result_kind)
                report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
            if (got.entry_address != want.entry_address)
                report_mismatch("entry_address", 64'(got.entry_address),
                                64'(want.entry_address));
            if (got.phys_addr != want.phys_addr)
                report_mismatch("phys_addr", 64'(got.phys_addr),
                                64'(want.phys_addr));
            if (got.status != want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.fault_level != want.fault_level)
                report_mismatch("fault_level", 64'(got.fault_level), 64'(want.fault_level));
        endtask
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [119:0]        s_tdata   = '0;
    logic [0:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [111:0]        m_tdata;
    logic [0:0]          m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PA_BITS-1:0]  cfg_data  = '0;

    logic                quiet     = 1'b0;
    int                  cycles    = 0;
    translation_tracker  tracker   = new();

    four_level_page_walker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycles, tracker.pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result({m_tuser[0], m_tdata[51:0], m_tdata[103:52],
                                  m_tdata[105:104], m_tdata[107:106]});
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Nonzero entry, large bit mostly clear so that walks reach the last table.
    function automatic logic [63:0] table_entry();
        logic [63:0] e;
        e = rand64();
        if ($urandom_range(0, 9) < 7)
            e[LARGE_PAGE_BIT] = 1'b0;
        if (e == '0)
            e = 64'h1;
        return e;
    endfunction

    initial
    begin : ready_gen
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_tready = 1'b0;
                hold--;
            end
            else
            begin
                m_tready = 1'b1;
                hold     = pick_gap();
            end
        end
    end

    task automatic send_beat(logic op, logic [VA_BITS-1:0] va,
                             logic [ENTRY_BITS-1:0] entry, logic ok);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = op;
        s_tdata  = {7'b0, ok, entry, va};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tracker.take_beat(op, va, entry, ok);
        @(negedge clk);
    endtask

    // Fields that the operation does not use carry random junk.
    task automatic request(logic [VA_BITS-1:0] va);
        send_beat(OP_REQUEST, va, rand64(), 1'($urandom_range(0, 1)));
    endtask

    task automatic respond(logic [ENTRY_BITS-1:0] entry, logic ok);
        send_beat(OP_RESPONSE, 48'(rand64()), entry, ok);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge clk);
    endtask

    task automatic write_root(logic [PA_BITS-1:0] base);
        // close any open walk so that nothing depends on the old table
        if (tracker.step != WALK_IDLE)
            respond(table_entry(), 1'b0);
        drain();
        repeat (4) @(negedge clk);
        cfg_data  = base;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.root_base = base;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_walk();
        int k;
        int r;
        request(48'(rand64()));
        for (k = 0; k < 6 && tracker.step != WALK_IDLE; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                request(48'(rand64()));
            else if (r < 7)
                break;
            else if (r < 10)
                respond(table_entry(), 1'b0);
            else if (r < 13)
                respond('0, 1'b1);
            else
                respond(table_entry(), 1'b1);
        end
    endtask

    task automatic run_walks(int target, int pause_at);
        while (tracker.beats_in < target)
        begin
            if (tracker.beats_in >= pause_at && pause_at > 0)
            begin
                // hold the sender until the pipeline has emptied
                drain();
                pause_at = 0;
            end
            if ($urandom_range(0, 99) < 8)
                respond(rand64(), 1'($urandom_range(0, 1)));
            else
                random_walk();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset root base of zero
        respond(rand64(), 1'b1);
        request('0);
        respond(64'h1000, 1'b1);
        respond(64'h2000, 1'b1);
        respond(64'h3000, 1'b1);
        respond(64'hFFFF_FFFF_FFFF_F0FF, 1'b1);
        request('1);
        respond('1, 1'b1);
        respond('1, 1'b1);
        request(48'h1234_5678_9ABC);
        respond(64'h8000_0000_0000_5003, 1'b1);
        respond(64'h0000_0000_0006_7003, 1'b1);
        respond(64'h000F_FFFF_FFE0_0083, 1'b1);
        request(48'(rand64()));
        respond(table_entry(), 1'b0);
        request(48'(rand64()));
        respond(64'h5000, 1'b1);
        respond(64'h6000, 1'b1);
        respond('0, 1'b1);
        request(48'h8000_0000_0000);
        respond(64'h7000, 1'b1);
        request(48'h7FFF_FFFF_FFFF);
        respond(64'h9000, 1'b1);
        respond(64'hA000, 1'b1);
        respond(64'hB000, 1'b1);
        respond('1, 1'b0);
        respond(rand64(), 1'b0);

        // top of the address space: entry addresses wrap
        write_root('1);
        request('1);
        request('0);
        respond('1, 1'b1);

        write_root(52'(rand64()));
        run_walks(500, 0);
        write_root(52'(rand64()));
        run_walks(1000, 750);
        write_root('0);
        run_walks(1400, 0);
        quiet = 1'b1;
        write_root(52'(rand64()));
        run_walks(RUN_ITEMS, 0);

        drain();
        repeat (8) @(posedge clk);
        $display("%0d beats sent, %0d results checked, 5 root table bases incl. zero and all ones",
                 tracker.beats_in, tracker.beats_out);
        $display("walks ended: %0d 4K, %0d 2M, %0d 1G pages, %0d faults, %0d stray responses",
                 tracker.pages_4k, tracker.pages_2m, tracker.pages_1g, tracker.faults,
                 tracker.idle_responses);
        if (tracker.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
